// File: design/fci_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes and bundle types for the friction contact impulse block.
package fci_pkg;

    localparam int DIM_DEFAULT = 3;

    localparam int VW   = 32;            // Q16.16 word
    localparam int NW   = 18;            // normal component
    localparam int MUW  = 21;            // friction coefficient
    localparam int IDXW = 3;             // register index
    localparam int DW   = VW + 1;        // relative velocity
    localparam int DNW  = DW + NW;       // d_i * n_i
    localparam int DOTW = DNW + 2;       // sum of three products
    localparam int PW   = DOTW - 16;     // normal projection p
    localparam int PPW  = PW + NW;       // p * n_i
    localparam int PNW  = PPW - 16;      // floor(p * n_i)
    localparam int TW   = PNW + 1;       // tangential component
    localparam int KW   = PW + MUW;      // (-p) * mu
    localparam int AW   = 31;            // scaled tangent magnitude
    localparam int SW   = 4;             // tangent scale shift
    localparam int SQW  = 2 * AW;
    localparam int SUMW = 64;
    localparam int ROOTW = SUMW / 2;
    localparam int LENW = ROOTW + 9;
    localparam int DENW = LENW + 16;
    localparam int QW   = 26;            // friction ratio bits
    localparam int PRW  = TW + QW + 1;   // t_i * r
    localparam int IW   = 44;            // impulse before saturation

    typedef enum logic [IDXW-1:0] {
        REG_OVX    = 3'd0,
        REG_OVY    = 3'd1,
        REG_OVZ    = 3'd2,
        REG_THR    = 3'd3,
        REG_MU     = 3'd4,
        REG_STICKY = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [VW-1:0]  ovx;
        logic [VW-1:0]  ovy;
        logic [VW-1:0]  ovz;
        logic [VW-1:0]  thr;
        logic [MUW-1:0] mu;
        logic           sticky;
    } t_cfg;

    typedef struct packed {
        logic [VW-1:0]        sdist;
        logic [2:0][NW-1:0]   norm;
        logic [2:0][VW-1:0]   vel;
    } t_item;

    typedef struct packed {
        logic                 hit;
        logic [2:0][DW-1:0]   d;
        logic [2:0][PNW-1:0]  pn;
        logic [2:0][TW-1:0]   t;
        logic [KW-1:0]        k;
        logic [SW-1:0]        s;
    } t_side;

    typedef struct packed {
        logic slide;
        logic lenz;
    } t_fric;

endpackage

// File: design/fci_if.sv
`timescale 1ns / 1ps
// Request, result and register write channels of the friction contact impulse block.
interface fci_item_if
    import fci_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] signed_dist;
    logic signed [NW-1:0] norm_x;
    logic signed [NW-1:0] norm_y;
    logic signed [NW-1:0] norm_z;
    logic signed [VW-1:0] pt_vel_x;
    logic signed [VW-1:0] pt_vel_y;
    logic signed [VW-1:0] pt_vel_z;

    modport source (output valid, signed_dist, norm_x, norm_y, norm_z,
                    pt_vel_x, pt_vel_y, pt_vel_z, input ready);
    modport sink   (input valid, signed_dist, norm_x, norm_y, norm_z,
                    pt_vel_x, pt_vel_y, pt_vel_z, output ready);
endinterface

interface fci_res_if
    import fci_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [VW-1:0] imp_x;
    logic signed [VW-1:0] imp_y;
    logic signed [VW-1:0] imp_z;

    modport source (output valid, hit, imp_x, imp_y, imp_z, input ready);
    modport sink   (input valid, hit, imp_x, imp_y, imp_z, output ready);
endinterface

interface fci_cfg_if
    import fci_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [IDXW-1:0] index;
    logic [VW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/friction_contact_impulse.sv
`timescale 1ns / 1ps
// Top level of the friction contact impulse block: registers, pipeline and channels.
//
// Streams point contacts one per clock: each request gives a signed distance, a unit
// normal and a point velocity, and the result carries the hit flag and the Coulomb
// friction impulse, saturated to Q16.16. The pipeline depth is set by the 32-stage
// square root for the tangent length and the 26-stage divider for the friction ratio;
// the whole pipeline advances as one and holds while the result register is not taken,
// so a full rate of one request per cycle holds whenever the sink keeps up. Register
// writes are taken at any time but belong in idle periods.
module friction_contact_impulse
    import fci_pkg::*;
#(
    parameter int DIMENSION = DIM_DEFAULT
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fci_item_if.sink   i_in,
    fci_res_if.source  o_res,
    fci_cfg_if.sink    i_cfg
);

    t_cfg             r_cfg;
    t_item            item;
    logic             en;

    logic             f_vld;
    t_side            f_side;
    logic [SUMW-1:0]  f_sum;
    logic             q_vld;
    t_side            q_side;
    logic [ROOTW-1:0] q_root;
    logic             d_vld;
    t_side            d_side;
    t_fric            d_fric;
    logic [QW-1:0]    d_q;
    logic             b_vld;
    logic             b_hit;
    logic [2:0][VW-1:0] b_imp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_OVX:    r_cfg.ovx    <= i_cfg.data;
                REG_OVY:    r_cfg.ovy    <= i_cfg.data;
                REG_OVZ:    r_cfg.ovz    <= i_cfg.data;
                REG_THR:    r_cfg.thr    <= i_cfg.data;
                REG_MU:     r_cfg.mu     <= i_cfg.data[MUW-1:0];
                REG_STICKY: r_cfg.sticky <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Advance every stage together; hold all while the result waits.
    assign en         = !b_vld || o_res.ready;
    assign i_in.ready = en;

    assign item.sdist = i_in.signed_dist;
    assign item.norm  = {i_in.norm_z, i_in.norm_y, i_in.norm_x};
    assign item.vel   = {i_in.pt_vel_z, i_in.pt_vel_y, i_in.pt_vel_x};

    fci_front #(.DIMENSION(DIMENSION)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_sum   (f_sum)
    );

    fci_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_val   (f_sum),
        .o_vld   (q_vld),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    fci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (q_vld),
        .i_side  (q_side),
        .i_root  (q_root),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_fric  (d_fric),
        .o_q     (d_q)
    );

    fci_back #(.DIMENSION(DIMENSION)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (d_vld),
        .i_side   (d_side),
        .i_fric   (d_fric),
        .i_q      (d_q),
        .i_sticky (r_cfg.sticky),
        .o_vld    (b_vld),
        .o_hit    (b_hit),
        .o_imp    (b_imp)
    );

    assign o_res.valid = b_vld;
    assign o_res.hit   = b_hit;
    assign o_res.imp_x = b_imp[0];
    assign o_res.imp_y = b_imp[1];
    assign o_res.imp_z = b_imp[2];

`ifndef SYNTH
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |->
            (o_res.imp_x == '0 && o_res.imp_y == '0 && o_res.imp_z == '0))
        else $error("impulse without a hit");

    a_planar_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (DIMENSION >= 3 || o_res.imp_z == '0))
        else $error("z impulse in two dimensions");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_in.ready)
        else $error("request taken while result is held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");
`endif

endmodule

// File: design/fci_front.sv
`timescale 1ns / 1ps
// Front pipeline: relative velocity, projection, tangent and squared tangent length.
module fci_front
    import fci_pkg::*;
#(
    parameter int DIMENSION = DIM_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  t_item           i_item,
    input  t_cfg            i_cfg,
    output logic            o_vld,
    output t_side           o_side,
    output logic [SUMW-1:0] o_sum
);

    localparam int NSTG = 8;
    localparam bit UseZ = (DIMENSION >= 3);

    logic [NSTG-1:0] r_vld;

    logic [2:0][VW-1:0]  ov;
    logic [2:0][DW-1:0]  n_d1;
    logic [2:0][NW-1:0]  n_n1;
    logic                n_lt1;
    logic [2:0][DW-1:0]  r1_d;
    logic [2:0][NW-1:0]  r1_n;
    logic                r1_lt;

    logic [2:0][DNW-1:0] n_dn;
    logic [2:0][DNW-1:0] r2_dn;
    logic [2:0][DW-1:0]  r2_d;
    logic [2:0][NW-1:0]  r2_n;
    logic                r2_lt;

    logic signed [DOTW-1:0] dot;
    logic [PW-1:0]       r3_p;
    logic                r3_hit;
    logic [2:0][DW-1:0]  r3_d;
    logic [2:0][NW-1:0]  r3_n;

    logic [PW:0]         negp;
    logic [KW-1:0]       n_k;
    logic [2:0][PPW-1:0] n_pp;
    logic [2:0][PPW-1:0] r4_pp;
    logic [KW-1:0]       r4_k;
    logic [2:0][DW-1:0]  r4_d;
    logic                r4_hit;

    logic [2:0][PNW-1:0] n_pn;
    logic [2:0][TW-1:0]  n_t;
    logic [2:0][PNW-1:0] r5_pn;
    logic [2:0][TW-1:0]  r5_t;
    logic [2:0][DW-1:0]  r5_d;
    logic [KW-1:0]       r5_k;
    logic                r5_hit;

    logic [2:0][TW-1:0]  mag;
    logic [TW-1:0]       mx;
    logic [SW-1:0]       n_s;
    logic [2:0][AW-1:0]  n_a;
    t_side               n_side;
    logic [2:0][AW-1:0]  r6_a;
    t_side               r6_side;

    logic [2:0][SQW-1:0] n_sq;
    logic [2:0][SQW-1:0] r7_sq;
    t_side               r7_side;

    logic [SUMW-1:0]     r8_sum;
    t_side               r8_side;

    always_comb begin
        ov    = {i_cfg.ovz, i_cfg.ovy, i_cfg.ovx};
        n_lt1 = $signed(i_item.sdist) < $signed(i_cfg.thr);
        for (int i = 0; i < 3; i++) begin
            if (i < 2 || UseZ) begin
                n_n1[i] = i_item.norm[i];
                n_d1[i] = $signed(i_item.vel[i]) - $signed(ov[i]);
            end else begin
                n_n1[i] = '0;
                n_d1[i] = '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dn[i] = $signed(r1_d[i]) * $signed(r1_n[i]);
        end
        dot = $signed(r2_dn[0]) + $signed(r2_dn[1]) + $signed(r2_dn[2]);
    end

    always_comb begin
        negp = -$signed(r3_p);
        n_k  = negp[PW-1:0] * i_cfg.mu;
        for (int i = 0; i < 3; i++) begin
            n_pp[i] = $signed(r3_p) * $signed(r3_n[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pn[i] = r4_pp[i][PPW-1:16];
            n_t[i]  = $signed(r4_d[i]) - $signed(n_pn[i]);
        end
    end

    // Scale the tangent so each magnitude fits 31 bits before squaring.
    always_comb begin
        mx = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = r5_t[i][TW-1] ? -r5_t[i] : r5_t[i];
            if (mag[i] > mx) begin
                mx = mag[i];
            end
        end
        n_s = '0;
        for (int b = AW; b < TW; b++) begin
            if (mx[b]) begin
                n_s = SW'(b - AW + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_a[i] = AW'(mag[i] >> n_s);
        end
        n_side.hit = r5_hit;
        n_side.d   = r5_d;
        n_side.pn  = r5_pn;
        n_side.t   = r5_t;
        n_side.k   = r5_k;
        n_side.s   = n_s;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = r6_a[i] * r6_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= n_d1;
            r1_n    <= n_n1;
            r1_lt   <= n_lt1;
            r2_dn   <= n_dn;
            r2_d    <= r1_d;
            r2_n    <= r1_n;
            r2_lt   <= r1_lt;
            r3_p    <= dot[DOTW-1:16];
            r3_hit  <= dot[DOTW-1] && r2_lt;
            r3_d    <= r2_d;
            r3_n    <= r2_n;
            r4_pp   <= n_pp;
            r4_k    <= n_k;
            r4_d    <= r3_d;
            r4_hit  <= r3_hit;
            r5_pn   <= n_pn;
            r5_t    <= n_t;
            r5_d    <= r4_d;
            r5_k    <= r4_k;
            r5_hit  <= r4_hit;
            r6_a    <= n_a;
            r6_side <= n_side;
            r7_sq   <= n_sq;
            r7_side <= r6_side;
            r8_sum  <= r7_sq[0] + r7_sq[1] + r7_sq[2];
            r8_side <= r7_side;
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_side = r8_side;
    assign o_sum  = r8_sum;

endmodule

// File: design/fci_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module fci_isqrt
    import fci_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [SUMW-1:0]  i_val,
    output logic             o_vld,
    output t_side            o_side,
    output logic [ROOTW-1:0] o_root
);

    localparam int NSTG = ROOTW;

    logic            r_vld  [NSTG];
    logic [SUMW-1:0] r_rem  [NSTG];
    logic [SUMW-1:0] r_root [NSTG];
    t_side           r_side [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_st
        localparam logic [SUMW-1:0] Bit = SUMW'(1) << (SUMW - 2 - 2 * g);
        logic            v_in;
        logic [SUMW-1:0] rem_in;
        logic [SUMW-1:0] root_in;
        t_side           side_in;
        logic [SUMW-1:0] trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign v_in    = i_vld;
            assign rem_in  = i_val;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
        end

        always_comb begin
            trial = root_in + Bit;
            ge    = rem_in >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? rem_in - trial : rem_in;
                r_root[g] <= ge ? (root_in >> 1) + Bit : root_in >> 1;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_side = r_side[NSTG-1];
    assign o_root = r_root[NSTG-1][ROOTW-1:0];

endmodule

// File: design/fci_div.sv
`timescale 1ns / 1ps
// Slide test and pipelined restoring division for the friction ratio.
module fci_div
    import fci_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [ROOTW-1:0] i_root,
    output logic             o_vld,
    output t_side            o_side,
    output t_fric            o_fric,
    output logic [QW-1:0]    o_q
);

    localparam int NSTG = QW;

    logic [LENW-1:0] len;
    logic [DENW-1:0] n_den;
    t_fric           n_fric;

    logic            r_p_vld;
    t_side           r_p_side;
    logic [DENW-1:0] r_p_den;
    t_fric           r_p_fric;

    logic            r_vld  [NSTG];
    logic [KW-1:0]   r_rem  [NSTG];
    logic [QW-1:0]   r_q    [NSTG];
    logic [DENW-1:0] r_den  [NSTG];
    t_side           r_side [NSTG];
    t_fric           r_fric [NSTG];

    always_comb begin
        len          = LENW'(i_root) << i_side.s;
        n_den        = {len, 16'b0};
        n_fric.slide = i_side.k < KW'(n_den);
        n_fric.lenz  = (i_root == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_side <= i_side;
            r_p_den  <= n_den;
            r_p_fric <= n_fric;
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_st
        logic            v_in;
        logic [KW-1:0]   rem_in;
        logic [QW-1:0]   q_in;
        logic [DENW-1:0] den_in;
        t_side           side_in;
        t_fric           fric_in;
        logic [KW:0]     sh;
        logic            ge;

        if (g == 0) begin : g_first
            assign v_in    = r_p_vld;
            assign rem_in  = r_p_side.k;
            assign q_in    = '0;
            assign den_in  = r_p_den;
            assign side_in = r_p_side;
            assign fric_in = r_p_fric;
        end else begin : g_next
            assign v_in    = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign q_in    = r_q[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
            assign fric_in = r_fric[g-1];
        end

        always_comb begin
            sh = {rem_in, 1'b0};
            ge = sh >= (KW + 1)'(den_in);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? KW'(sh - (KW + 1)'(den_in)) : sh[KW-1:0];
                r_q[g]    <= {q_in[QW-2:0], ge};
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
                r_fric[g] <= fric_in;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_side = r_side[NSTG-1];
    assign o_fric = r_fric[NSTG-1];
    assign o_q    = r_q[NSTG-1];

endmodule

// File: design/fci_back.sv
`timescale 1ns / 1ps
// Friction term, impulse selection, saturation and the result register.
module fci_back
    import fci_pkg::*;
#(
    parameter int DIMENSION = DIM_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  t_side               i_side,
    input  t_fric               i_fric,
    input  logic [QW-1:0]       i_q,
    input  logic                i_sticky,
    output logic                o_vld,
    output logic                o_hit,
    output logic [2:0][VW-1:0]  o_imp
);

    localparam bit UseZ = (DIMENSION >= 3);

    function automatic logic [VW-1:0] sat32(input logic [IW-1:0] v);
        logic [VW-1:0] res;
        if (&v[IW-1:VW-1] || ~|v[IW-1:VW-1]) begin
            res = v[VW-1:0];
        end else if (v[IW-1]) begin
            res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            res = {1'b0, {(VW-1){1'b1}}};
        end
        return res;
    endfunction

    logic [2:0][PRW-1:0] n_prod;
    logic                r_a_vld;
    logic [2:0][PRW-1:0] r_a_prod;
    t_side               r_a_side;
    t_fric               r_a_fric;

    logic [PRW:0]        neg   [3];
    logic [IW-1:0]       imp   [3];
    logic [2:0][VW-1:0]  n_imp;

    logic                r_vld;
    logic                r_hit;
    logic [2:0][VW-1:0]  r_imp;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = $signed(i_side.t[i]) * $signed({1'b0, i_q});
        end
    end

    // Slide, unless sticky is set, adds the friction term to -p*n unless the tangent has zero length.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i] = -$signed(r_a_prod[i]);
            if (!r_a_side.hit) begin
                imp[i] = '0;
            end else if (i_sticky || !r_a_fric.slide) begin
                imp[i] = -$signed(r_a_side.d[i]);
            end else if (r_a_fric.lenz) begin
                imp[i] = -$signed(r_a_side.pn[i]);
            end else begin
                imp[i] = $signed(neg[i][PRW:QW]) - $signed(r_a_side.pn[i]);
            end
            n_imp[i] = sat32(imp[i]);
        end
        if (!UseZ) begin
            n_imp[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_vld   <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod <= n_prod;
            r_a_side <= i_side;
            r_a_fric <= i_fric;
            r_hit    <= r_a_side.hit;
            r_imp    <= n_imp;
        end
    end

    assign o_vld = r_vld;
    assign o_hit = r_hit;
    assign o_imp = r_imp;

endmodule
